/* src/mts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg
// shared types and codes for the max tracking stack
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 11;

    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_MAX  = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [VALUE_W-1:0] push_value;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [1:0]                status;
        logic [COUNT_W-1:0]        entry_count;
    } t_out;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

endpackage
`default_nettype wire

/* src/mts_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mts_cell
// one stack entry; takes the upper neighbor on push, the lower one on pop
// ----------------------------------------------------------------------------
module mts_cell
    import mts_pkg::*;
(
    input  wire logic               i_clk,
    input  wire t_shift             i_ctl,
    input  wire logic [VALUE_W-1:0] i_from_up,
    input  wire logic [VALUE_W-1:0] i_from_down,
    output logic [VALUE_W-1:0]      o_data
);

    logic [VALUE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_data <= i_from_up;
        end else if (i_ctl.pop) begin
            r_data <= i_from_down;
        end
    end

    assign o_data = r_data;

endmodule
`default_nettype wire

/* src/mts_stack.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mts_stack
// row of shifting cells; cell 0 is the top of the stack
// ----------------------------------------------------------------------------
module mts_stack
    import mts_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire t_shift             i_ctl,
    input  wire logic [VALUE_W-1:0] i_push_data,
    output logic [VALUE_W-1:0]      o_top
);

    logic [VALUE_W-1:0] w_cell [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] w_up;
        logic [VALUE_W-1:0] w_down;

        if (g == 0) begin : g_first
            assign w_up = i_push_data;
        end else begin : g_inner_up
            assign w_up = w_cell[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_down = '0;
        end else begin : g_inner_down
            assign w_down = w_cell[g+1];
        end

        mts_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_data      (w_cell[g])
        );
    end

    assign o_top = w_cell[0];

endmodule
`default_nettype wire

/* src/max_tracking_stack.sv */
// a result is registered and appears in the cycle after its request transfer
// throughput: one request per cycle while results are taken; a request moves each cell row by at most one place
// a stalled result blocks new requests only while it still waits to be taken
// reset clears both counts and the output valid; cell contents are not cleared
// pop and query read only the top cells, so no read of an unwritten entry occurs
`default_nettype none
// ----------------------------------------------------------------------------
// max_tracking_stack
// lifo of signed values with a second shifting row that tracks the maximum
// ----------------------------------------------------------------------------
module max_tracking_stack
    import mts_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;

    logic [CW-1:0]      r_val_count, n_val_count;
    logic [CW-1:0]      r_max_count, n_max_count;
    logic               r_out_valid;
    t_out               r_out_data;

    logic               w_acc;
    logic               w_full;
    logic               w_empty;
    logic               w_max_empty;
    logic [VALUE_W-1:0] w_val_top;
    logic [VALUE_W-1:0] w_max_top;
    t_shift             w_val_ctl;
    t_shift             w_max_ctl;
    logic [VALUE_W-1:0] w_result;
    logic [1:0]         w_status;
    logic [EW-1:0]      w_count_ext;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_acc       = i_in_valid && o_in_ready;
    assign w_full      = (r_val_count == CW'(DEPTH));
    assign w_empty     = (r_val_count == '0);
    assign w_max_empty = (r_max_count == '0);

    mts_stack #(.DEPTH(DEPTH)) u_val_stack (
        .i_clk       (i_clk),
        .i_ctl       (w_val_ctl),
        .i_push_data (i_in_data.push_value),
        .o_top       (w_val_top)
    );

    mts_stack #(.DEPTH(DEPTH)) u_max_stack (
        .i_clk       (i_clk),
        .i_ctl       (w_max_ctl),
        .i_push_data (i_in_data.push_value),
        .o_top       (w_max_top)
    );

    always_comb begin
        w_result    = '0;
        w_status    = ST_OK;
        w_val_ctl   = '0;
        w_max_ctl   = '0;
        n_val_count = r_val_count;
        n_max_count = r_max_count;
        if (w_acc) begin
            unique case (i_in_data.req_type)
                REQ_PUSH: begin
                    if (w_full) begin
                        w_status = ST_OVERFLOW;
                    end else begin
                        w_val_ctl.push = 1'b1;
                        n_val_count    = r_val_count + CW'(1);
                        if (w_max_empty || (r_max_count != CW'(DEPTH) &&
                            $signed(w_max_top) <= i_in_data.push_value)) begin
                            w_max_ctl.push = 1'b1;
                            n_max_count    = r_max_count + CW'(1);
                        end
                    end
                end
                REQ_POP: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        w_val_ctl.pop = 1'b1;
                        n_val_count   = r_val_count - CW'(1);
                        w_result      = w_val_top;
                        if (!w_max_empty && w_max_top == w_val_top) begin
                            w_max_ctl.pop = 1'b1;
                            n_max_count   = r_max_count - CW'(1);
                        end
                    end
                end
                REQ_MAX: begin
                    if (w_empty || w_max_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        w_result = w_max_top;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign w_count_ext = EW'(n_val_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val_count <= '0;
            r_max_count <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_val_count <= n_val_count;
            r_max_count <= n_max_count;
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out_data.result_value <= w_result;
            r_out_data.status       <= w_status;
            r_out_data.entry_count  <= w_count_ext[COUNT_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef NO_ASSERTIONS
    a_max_le_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_max_count <= r_val_count)
        else $error("max count exceeds value count");

    a_empty_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_val_count == '0) == (r_max_count == '0))
        else $error("max row empty state disagrees with value row");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_val_count <= CW'(DEPTH))
        else $error("value count beyond depth");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in_data.req_type == REQ_PUSH && !w_full)
        |=> (r_val_count == $past(r_val_count) + CW'(1)))
        else $error("push did not grow the stack");

    a_shift_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_val_ctl.push && w_val_ctl.pop) && !(w_max_ctl.push && w_max_ctl.pop))
        else $error("cell row pushed and popped at once");
`endif

endmodule
`default_nettype wire
